// ----- hdl/glsgd_pkg.sv -----
// ----------------------------------------------------------------------------
// glsgd_pkg
// Shared types and constants for the 1D graph layout update block.
// ----------------------------------------------------------------------------
`default_nettype none

package glsgd_pkg;

   localparam int unsigned NODE_W   = 16;
   localparam int unsigned COORD_W  = 40;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned TARGET_W = 41;
   localparam int unsigned POS_W    = 64;
   localparam int unsigned STEP_W   = 63;
   localparam int unsigned ETA_W    = 48;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_TERM  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // one classified request waiting for the back end
   typedef struct packed {
      kind_type              kind;
      logic [NODE_W-1:0]     node_a;
      logic                  end_a;
      logic [NODE_W-1:0]     node_b;
      logic                  end_b;
      logic                  ok_a;     // node_a addresses a stored node
      logic                  skip;     // term that moves nothing
      logic [TARGET_W-1:0]   target;
      logic [POS_W-1:0]      write_value;
   } entry_type;

endpackage

`default_nettype wire

// ----- hdl/graph_layout_sgd_update_1d.sv -----
// Terms other than those with mu = 1 run a bit-serial multiply and restoring divide in
// the back end, over D = max(64, 41 + FRACTION_BITS) bits; writes, reads, clears, skipped
// terms and terms with mu = 1 bypass both.
// The back end takes one request at a time; the queue and result register decouple it.
// Reset: synchronous; clears control state and the maximum, sets eta to 1.0, no memory clear.
// ----------------------------------------------------------------------------
// graph_layout_sgd_update_1d
// One-dimensional path-guided SGD update over stored node-end positions.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_layout_sgd_update_1d import glsgd_pkg::*; #(
   parameter int NODE_COUNT    = 65536,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // node_a[15:0] end_a[16] ref_pos_a[56:17] len_a[88:57] node_b[104:89]
   // end_b[105] ref_pos_b[145:106] len_b[177:146] write_value[241:178]
   input  wire logic [247:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]   req_tuser,
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // read_value[63:0] applied[64] step_size[127:65] max_step[190:128]
   output logic [191:0]      rsp_tdata,
   // learning rate write channel, unsigned Q32.16
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [47:0]  csr_data
);

   logic [ETA_W-1:0] eta_ff;
   entry_type        front_entry, q_entry;
   logic             q_valid, q_pop;

   // the user must rewrite eta only while the block is idle; not enforced here; always accept
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff <= 48'd65536;
      end else if (csr_valid) begin
         eta_ff <= csr_data;
      end
   end

   // classify the incoming request
   glsgd_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .kind        (kind_type'(req_tuser)),
      .node_a      (req_tdata[15:0]),
      .end_a       (req_tdata[16]),
      .ref_pos_a   (req_tdata[56:17]),
      .len_a       (req_tdata[88:57]),
      .node_b      (req_tdata[104:89]),
      .end_b       (req_tdata[105]),
      .ref_pos_b   (req_tdata[145:106]),
      .len_b       (req_tdata[177:146]),
      .write_value (req_tdata[241:178]),
      .entry       (front_entry)
   );

   // hold classified requests until the back end is free
   glsgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_entry (front_entry),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_entry  (q_entry)
   );

   // carry out memory accesses and term updates
   glsgd_back #(
      .NODE_COUNT    (NODE_COUNT),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .eta        (eta_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_entry    (q_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- hdl/glsgd_front.sv -----
// ----------------------------------------------------------------------------
// glsgd_front
// Classify a request: target distance, range checks and skip decision.
// ----------------------------------------------------------------------------
`default_nettype none

module glsgd_front import glsgd_pkg::*; #(
   parameter int NODE_COUNT = 65536
) (
   input  wire kind_type            kind,
   input  wire logic [NODE_W-1:0]   node_a,
   input  wire logic                end_a,
   input  wire logic [COORD_W-1:0]  ref_pos_a,
   input  wire logic [LEN_W-1:0]    len_a,
   input  wire logic [NODE_W-1:0]   node_b,
   input  wire logic                end_b,
   input  wire logic [COORD_W-1:0]  ref_pos_b,
   input  wire logic [LEN_W-1:0]    len_b,
   input  wire logic [POS_W-1:0]    write_value,
   output entry_type                entry
);

   logic [TARGET_W-1:0] pa, pb, target;
   logic                ok_a, ok_b;

   always_comb begin
      pa     = TARGET_W'(ref_pos_a) + (end_a ? TARGET_W'(len_a) : '0);
      pb     = TARGET_W'(ref_pos_b) + (end_b ? TARGET_W'(len_b) : '0);
      target = (pa >= pb) ? (pa - pb) : (pb - pa);
      ok_a   = {16'd0, node_a} < 32'(NODE_COUNT);
      ok_b   = {16'd0, node_b} < 32'(NODE_COUNT);

      entry.kind        = kind;
      entry.node_a      = node_a;
      entry.end_a       = end_a;
      entry.node_b      = node_b;
      entry.end_b       = end_b;
      entry.ok_a        = ok_a;
      entry.skip        = (node_a == node_b) || !ok_a || !ok_b || (target == '0);
      entry.target      = target;
      entry.write_value = write_value;
   end

endmodule

`default_nettype wire

// ----- hdl/glsgd_queue.sv -----
// ----------------------------------------------------------------------------
// glsgd_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module glsgd_queue import glsgd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   output logic            push_ready,
   input  wire entry_type  push_entry,
   output logic            pop_valid,
   input  wire logic       pop_ready,
   output entry_type       pop_entry
);

   entry_type  slots_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      pop_entry  = slots_ff[head_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      head_in    = pop  ? ~head_ff : head_ff;
      tail_in    = push ? ~tail_ff : tail_ff;
      count_in   = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[tail_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/glsgd_back.sv -----
// ----------------------------------------------------------------------------
// glsgd_back
// Sequencer over the position memory: read/write, term update with serial
// multiply and divide, running maximum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module glsgd_back import glsgd_pkg::*; #(
   parameter int NODE_COUNT    = 65536,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ETA_W-1:0]  eta,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire entry_type         q_entry,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [191:0]           rsp_tdata
);

   localparam int IW    = $clog2(NODE_COUNT);
   localparam int AW    = IW + 1;
   localparam int DEPTH = 2 * NODE_COUNT;
   localparam int TQ_W  = TARGET_W + FRACTION_BITS;
   localparam int D_W   = (TQ_W > POS_W) ? TQ_W : POS_W;
   localparam int NUM_W = ETA_W + D_W;
   localparam int Q_W   = D_W - 1;
   localparam int DIV_W = TQ_W + 1;
   localparam int R_W   = DIV_W + 1;
   localparam int CNT_W = $clog2(D_W + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RDWAIT, S_LOADA, S_LOADB, S_DIFF, S_MUL, S_DSET, S_DIV,
      S_MOVE, S_WRB, S_RESP
   } state_type;

   state_type         state_ff;
   entry_type         cur_ff;
   logic [POS_W-1:0]  mem [DEPTH];
   logic [POS_W-1:0]  mem_q_ff;
   logic              we;
   logic [AW-1:0]     wa, ra;
   logic [POS_W-1:0]  wd;

   logic [POS_W-1:0]  xa_ff, xb_ff, mag_ff, newb_ff, s_ff;
   logic              dx_neg_ff, d_neg_ff;
   logic [D_W-1:0]    dsh_ff;
   logic [NUM_W-1:0]  acc_ff;
   logic [DIV_W-1:0]  div_ff, rem_ff;
   logic [Q_W-1:0]    nlo_ff, q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [STEP_W-1:0] max_ff, max_in;
   logic [POS_W-1:0]  res_read_ff;
   logic              res_applied_ff;
   logic [STEP_W-1:0] res_step_ff;
   logic              rsp_valid_ff;
   logic [191:0]      rsp_data_ff;

   logic [D_W-1:0]    mag_ext, tq_ext, d_val;
   logic              d_neg, mu_one, dx_neg, out_free, qbit, up_a;
   logic [R_W-1:0]    trial;
   logic [POS_W-1:0]  new_a, new_b, mag_val;

   function automatic logic [POS_W-1:0] sat_move(input logic [POS_W-1:0] x,
                                                 input logic up,
                                                 input logic [POS_W-1:0] s);
      logic signed [POS_W+1:0] r;
      logic [POS_W-1:0]        res;
      if (up) begin
         r = $signed({{2{x[POS_W-1]}}, x}) + $signed({2'b00, s});
      end else begin
         r = $signed({{2{x[POS_W-1]}}, x}) - $signed({2'b00, s});
      end
      if (r[POS_W+1] && (r[POS_W:POS_W-1] != 2'b11)) begin
         res = {1'b1, {(POS_W-1){1'b0}}};
      end else if (!r[POS_W+1] && (r[POS_W:POS_W-1] != 2'b00)) begin
         res = {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         res = r[POS_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      q_pop    = (state_ff == S_IDLE) && q_valid;

      // memory ports
      we = 1'b0;
      wa = {IW'(q_entry.node_a), q_entry.end_a};
      wd = q_entry.write_value;
      ra = {IW'(q_entry.node_a), q_entry.end_a};
      case (state_ff)
         S_IDLE: begin
            we = q_valid && (q_entry.kind == KIND_WRITE) && q_entry.ok_a;
         end
         S_LOADA: begin
            ra = {IW'(cur_ff.node_b), cur_ff.end_b};
         end
         S_MOVE: begin
            we = 1'b1;
            wa = {IW'(cur_ff.node_a), cur_ff.end_a};
            wd = new_a;
         end
         S_WRB: begin
            we = 1'b1;
            wa = {IW'(cur_ff.node_b), cur_ff.end_b};
            wd = newb_ff;
         end
         default: begin
         end
      endcase

      // distance between the two ends
      dx_neg  = $signed(xa_ff) < $signed(mem_q_ff);
      mag_val = dx_neg ? (mem_q_ff - xa_ff) : (xa_ff - mem_q_ff);

      // signed difference to the target, in position units
      mag_ext = D_W'(mag_ff);
      tq_ext  = D_W'(cur_ff.target) << FRACTION_BITS;
      d_neg   = mag_ext < tq_ext;
      d_val   = d_neg ? (tq_ext - mag_ext) : (mag_ext - tq_ext);
      mu_one  = ETA_W'(eta >> FRACTION_BITS) >= ETA_W'(cur_ff.target);

      // one restoring divide step
      trial = {rem_ff, nlo_ff[Q_W-1]};
      qbit  = trial >= R_W'(div_ff);

      up_a  = d_neg_ff != dx_neg_ff;
      new_a = sat_move(xa_ff, up_a, s_ff);
      new_b = sat_move(xb_ff, !up_a, s_ff);

      if (cur_ff.kind == KIND_CLEAR) begin
         max_in = '0;
      end else if (res_applied_ff && (res_step_ff > max_ff)) begin
         max_in = res_step_ff;
      end else begin
         max_in = max_ff;
      end

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      mem_q_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new result when the register frees up, else drop it once taken
         if ((state_ff == S_RESP) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff         <= q_entry;
                  res_read_ff    <= '0;
                  res_applied_ff <= 1'b0;
                  res_step_ff    <= '0;
                  if (q_entry.kind == KIND_READ) begin
                     state_ff <= S_RDWAIT;
                  end else if ((q_entry.kind == KIND_TERM) && !q_entry.skip) begin
                     state_ff <= S_LOADA;
                  end else begin
                     state_ff <= S_RESP;
                  end
               end
            end
            S_RDWAIT: begin
               res_read_ff <= cur_ff.ok_a ? mem_q_ff : '0;
               state_ff    <= S_RESP;
            end
            S_LOADA: begin
               xa_ff    <= mem_q_ff;
               state_ff <= S_LOADB;
            end
            S_LOADB: begin
               xb_ff     <= mem_q_ff;
               dx_neg_ff <= dx_neg;
               mag_ff    <= mag_val;
               state_ff  <= S_DIFF;
            end
            S_DIFF: begin
               d_neg_ff <= d_neg;
               dsh_ff   <= d_val;
               acc_ff   <= '0;
               div_ff   <= DIV_W'(cur_ff.target) << (FRACTION_BITS + 1);
               cnt_ff   <= CNT_W'(D_W - 1);
               if (mu_one) begin
                  s_ff     <= POS_W'(d_val >> 1);
                  state_ff <= S_MOVE;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               // shift-add, most significant bit of the difference first
               acc_ff <= {acc_ff[NUM_W-2:0], 1'b0}
                         + (dsh_ff[D_W-1] ? NUM_W'(eta) : '0);
               dsh_ff <= {dsh_ff[D_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= S_DSET;
               end
            end
            S_DSET: begin
               rem_ff   <= DIV_W'(acc_ff >> Q_W);
               nlo_ff   <= Q_W'(acc_ff);
               q_ff     <= '0;
               cnt_ff   <= CNT_W'(Q_W - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= qbit ? DIV_W'(trial - R_W'(div_ff)) : DIV_W'(trial);
               nlo_ff <= {nlo_ff[Q_W-2:0], 1'b0};
               q_ff   <= {q_ff[Q_W-2:0], qbit};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  s_ff     <= POS_W'({q_ff[Q_W-2:0], qbit});
                  state_ff <= S_MOVE;
               end
            end
            S_MOVE: begin
               newb_ff        <= new_b;
               res_applied_ff <= 1'b1;
               res_step_ff    <= s_ff[POS_W-1] ? '1 : s_ff[STEP_W-1:0];
               state_ff       <= S_WRB;
            end
            S_WRB: begin
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  max_ff       <= max_in;
                  rsp_data_ff  <= {1'b0, max_in, res_step_ff, res_applied_ff,
                                   res_read_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 1D graph layout SGD update block. Requests go in
// through the request stream, every result is checked field by field against
// an in-bench model of the position store, the step arithmetic and the running
// maximum. Directed cases come first, then random phases at several learning
// rates, with bursty requests, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import glsgd_pkg::*;

   localparam int NODES     = 65536;
   localparam int FRAC      = 16;
   localparam int DRAIN     = 200;   // cycles after the last result, above term latency
   localparam int HOLD_CYCLES = 600;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] POS_MIN = 64'h8000_0000_0000_0000;
   localparam logic [47:0] ETA_ONE = 48'd65536;
   localparam logic [47:0] ETA_TOP = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      kind_type      kind;
      logic [15:0]   node_a;
      logic          end_a;
      logic [39:0]   ref_pos_a;
      logic [31:0]   len_a;
      logic [15:0]   node_b;
      logic          end_b;
      logic [39:0]   ref_pos_b;
      logic [31:0]   len_b;
      logic [63:0]   write_value;
   } layout_req;

   typedef struct packed {
      logic [63:0] read_value;
      logic        applied;
      logic [62:0] step_size;
      logic [62:0] max_step;
   } layout_rsp;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [247:0]  req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [191:0]  rsp_tdata;
   logic          csr_valid;
   logic          csr_ready;
   logic [47:0]   csr_data;

   // model state
   logic signed [63:0] end_pos [int];
   logic [62:0]        largest_step;
   logic [47:0]        eta;
   int                 written_ends [$];

   layout_rsp expected_rsp [$];
   int        errors;
   int        burst_left;
   int        hold_left;
   int        hold_asked;
   int        hold_seen;
   int        rx_mode;
   int        rx_count;

   graph_layout_sgd_update_1d dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------

   // Add or subtract a step, clamped to the signed 64-bit range.
   function automatic logic [63:0] sat_move(logic [63:0] x, bit up, logic [63:0] s);
      logic signed [65:0] v;
      v = up ? $signed({{2{x[63]}}, x}) + $signed({2'b00, s})
             : $signed({{2{x[63]}}, x}) - $signed({2'b00, s});
      if (v > $signed({2'b00, POS_MAX})) return POS_MAX;
      if (v < $signed({2'b11, POS_MIN})) return POS_MIN;
      return v[63:0];
   endfunction

   // Work out one result and advance the stored positions and maximum.
   function automatic layout_rsp layout_update(layout_req r);
      layout_rsp          o;
      logic [40:0]        pa, pb, target;
      logic signed [63:0] xa, xb;
      logic [63:0]        mag, s64;
      logic [127:0]       tq, d, s;
      bit                 dx_neg, d_neg, a_up;
      int                 ia, ib;
      o  = '0;
      ia = int'(r.node_a) * 2 + int'(r.end_a);
      ib = int'(r.node_b) * 2 + int'(r.end_b);
      case (r.kind)
         KIND_WRITE: begin
            end_pos[ia] = r.write_value;
         end
         KIND_READ: begin
            o.read_value = end_pos[ia];
         end
         KIND_CLEAR: begin
            largest_step = '0;
         end
         default: begin
            pa = {1'b0, r.ref_pos_a} + (r.end_a ? {9'd0, r.len_a} : 41'd0);
            pb = {1'b0, r.ref_pos_b} + (r.end_b ? {9'd0, r.len_b} : 41'd0);
            target = (pa >= pb) ? pa - pb : pb - pa;
            if (r.node_a != r.node_b && target != 0) begin
               xa = end_pos[ia];
               xb = end_pos[ib];
               dx_neg = xa < xb;
               mag = dx_neg ? xb - xa : xa - xb;
               tq = {87'd0, target} << FRAC;
               d_neg = {64'd0, mag} < tq;
               d = d_neg ? tq - {64'd0, mag} : {64'd0, mag} - tq;
               // mu = 1 when the integer part of eta reaches the target
               if ((eta >> FRAC) >= target)
                  s = d >> 1;
               else
                  s = ({80'd0, eta} * d) / (tq << 1);
               s64 = (s[127:64] != 0) ? '1 : s[63:0];
               a_up = d_neg != dx_neg;
               end_pos[ia] = sat_move(xa, a_up, s64);
               end_pos[ib] = sat_move(xb, !a_up, s64);
               o.applied   = 1'b1;
               o.step_size = s64[63] ? POS_MAX[62:0] : s64[62:0];
               if (o.step_size > largest_step) largest_step = o.step_size;
            end
         end
      endcase
      o.max_step = largest_step;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one request, hold it until taken, then maybe idle before the next.
   task automatic send_req(layout_req r);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {6'd0, r.write_value, r.len_b, r.ref_pos_b, r.end_b, r.node_b,
                     r.len_a, r.ref_pos_a, r.end_a, r.node_a};
      do @(posedge clock); while (!req_tready);
      expected_rsp = {expected_rsp, layout_update(r)};
      if (r.kind == KIND_WRITE)
         written_ends = {written_ends, int'(r.node_a) * 2 + int'(r.end_a)};
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      int n;
      req_tvalid <= 1'b0;
      n = 0;
      while (expected_rsp.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (DRAIN) @(posedge clock);
   endtask

   // Write the learning rate; only called with nothing in flight.
   task automatic write_eta(logic [47:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      eta = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic layout_req simple_req(kind_type k, int node, bit e, logic [63:0] v);
      layout_req r;
      r = '0;
      r.kind = k;
      r.node_a = 16'(node);
      r.end_a = e;
      r.write_value = v;
      return r;
   endfunction

   function automatic layout_req term_req(int na, bit ea, logic [39:0] pa,
                                          int nb, bit eb, logic [39:0] pb);
      layout_req r;
      r = '0;
      r.kind = KIND_TERM;
      r.node_a = 16'(na); r.end_a = ea; r.ref_pos_a = pa;
      r.node_b = 16'(nb); r.end_b = eb; r.ref_pos_b = pb;
      r.len_a = $urandom; r.len_b = $urandom;
      return r;
   endfunction

   function automatic logic [63:0] random_position();
      case ($urandom_range(0, 9))
         0: return POS_MAX;
         1: return POS_MIN;
         2: return {$urandom, $urandom};
         default: return {{32{1'b0}}, $urandom} - 64'h0000_0000_8000_0000;
      endcase
   endfunction

   // Mostly terms on stored ends with random coordinates; some writes, reads, clears.
   function automatic layout_req random_req();
      layout_req r;
      int        pick, ia, ib;
      r = '0;
      pick = $urandom_range(0, 99);
      ia = written_ends[$urandom_range(0, written_ends.size() - 1)];
      ib = written_ends[$urandom_range(0, written_ends.size() - 1)];
      if (pick < 12) begin
         r = simple_req(KIND_WRITE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, NODES - 1)
                        : ia >> 1, 1'(ia), random_position());
      end else if (pick < 28) begin
         r = simple_req(KIND_READ, ia >> 1, 1'(ia), {$urandom, $urandom});
      end else if (pick < 32) begin
         r = simple_req(KIND_CLEAR, $urandom, 1'($urandom), {$urandom, $urandom});
      end else begin
         r.kind = KIND_TERM;
         r.node_a = 16'(ia >> 1); r.end_a = 1'(ia);
         r.node_b = 16'(ib >> 1); r.end_b = 1'(ib);
         if ($urandom_range(0, 3) == 0) begin
            r.ref_pos_a = 40'({$urandom, $urandom});
            r.ref_pos_b = 40'({$urandom, $urandom});
            r.len_a = $urandom;
            r.len_b = $urandom;
         end else begin
            r.ref_pos_a = 40'($urandom_range(0, 300));
            r.ref_pos_b = 40'($urandom_range(0, 300));
            r.len_a = $urandom_range(0, 40);
            r.len_b = $urandom_range(0, 40);
         end
         r.write_value = {$urandom, $urandom};
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   task automatic test_write_read();
      send_req(simple_req(KIND_WRITE, 0, 1'b0, POS_MAX));
      send_req(simple_req(KIND_WRITE, 0, 1'b1, POS_MIN));
      send_req(simple_req(KIND_WRITE, NODES - 1, 1'b1, 64'h0));
      send_req(simple_req(KIND_WRITE, NODES - 1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_req(simple_req(KIND_READ, 0, 1'b0, 64'h0));
      send_req(simple_req(KIND_READ, 0, 1'b1, 64'h0));
      send_req(simple_req(KIND_READ, NODES - 1, 1'b1, 64'h0));
      send_req(simple_req(KIND_READ, NODES - 1, 1'b0, 64'h0));
   endtask

   task automatic test_term_cases();
      // same node is skipped
      send_req(term_req(0, 1'b0, 40'd0, 0, 1'b1, 40'd500));
      // matching coordinates give a zero target: skip
      send_req(simple_req(KIND_WRITE, 1, 1'b0, 64'h0));
      send_req(simple_req(KIND_WRITE, 2, 1'b0, 64'h0));
      send_req(term_req(1, 1'b0, 40'd77, 2, 1'b0, 40'd77));
      // equal positions, dx taken as positive
      send_req(term_req(1, 1'b0, 40'd0, 2, 1'b0, 40'd5));
      // far apart at the limits
      send_req(simple_req(KIND_WRITE, 3, 1'b0, POS_MAX));
      send_req(simple_req(KIND_WRITE, 4, 1'b0, POS_MIN));
      send_req(term_req(3, 1'b0, 40'd0, 4, 1'b0, 40'd1));
      send_req(term_req(4, 1'b0, 40'hFF_FFFF_FFFF, 3, 1'b0, 40'd0));
      send_req(simple_req(KIND_READ, 3, 1'b0, 64'h0));
      send_req(simple_req(KIND_READ, 4, 1'b0, 64'h0));
      send_req(simple_req(KIND_CLEAR, 0, 1'b0, 64'h0));
      send_req(term_req(1, 1'b0, 40'd0, 2, 1'b0, 40'd3));
   endtask

   task automatic test_random_phase(logic [47:0] rate, int count);
      int i;
      write_eta(rate);
      for (i = 0; i < count; i++) send_req(random_req());
   endtask

   task automatic test_backpressure();
      int i;
      hold_asked++;
      for (i = 0; i < 60; i++) send_req(random_req());
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         // start the long hold-off while the sender keeps offering
         hold_seen  <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         // change stall regime at random intervals, one regime never stalls
         if (rx_count == 0) rx_mode <= $urandom_range(0, 2);
         rx_count <= (rx_count == 0) ? $urandom_range(50, 400) : rx_count - 1;
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      layout_rsp got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[63:0], rsp_tdata[64], rsp_tdata[127:65], rsp_tdata[190:128]};
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_rsp.pop_front();
            if (got.read_value !== want.read_value || got.applied !== want.applied ||
                got.step_size !== want.step_size || got.max_step !== want.max_step) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: read %h/%h applied %b/%b step %h/%h max %h/%h",
                           want.read_value, got.read_value, want.applied, got.applied,
                           want.step_size, got.step_size, want.max_step, got.max_step);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      int i;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= KIND_WRITE;
      csr_valid    <= 1'b0;
      csr_data     <= '0;
      burst_left   = 8;
      largest_step = '0;
      eta          = ETA_ONE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_write_read();
      test_term_cases();
      // fill a pool of stored ends for the random part
      for (i = 5; i < 24; i++) begin
         send_req(simple_req(KIND_WRITE, i, 1'b0, random_position()));
         send_req(simple_req(KIND_WRITE, i, 1'b1, random_position()));
      end
      test_random_phase(ETA_ONE, 380);
      test_random_phase(48'd0, 300);
      test_random_phase(ETA_TOP, 360);
      test_random_phase(48'({$urandom_range(1, 400), 16'd0}) |
                        48'($urandom_range(0, 65535)), 380);
      test_backpressure();
      test_random_phase(48'({$urandom, $urandom}), 380);

      wait_idle();
      if (errors == 0 && expected_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #40ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
